>>> sv/terminal_byte_cursor_engine_core_defines.svh
// Assertion macros shared by the cursor engine RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TERMINAL_BYTE_CURSOR_ENGINE_CORE_DEFINES_SVH
`define TERMINAL_BYTE_CURSOR_ENGINE_CORE_DEFINES_SVH

// Check that an expression holds at every clock edge outside reset.
`define TBCE_ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a same-cycle implication.
`define TBCE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle.
`define TBCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/tbce_pkg.sv
// Types and constants of the terminal byte cursor engine.
// No dependencies; used by terminal_byte_cursor_engine_core.
package tbce_pkg;

  // Field widths
  localparam int unsigned ColW    = 8;
  localparam int unsigned RowW    = 8;
  localparam int unsigned CodeW   = 21;
  localparam int unsigned EscCntW = 7;
  // Write count of one burst; tab stops go up to 31
  localparam int unsigned CntW    = 5;

  // Register reset values
  localparam logic [ColW-1:0]  ColumnsRst = 8'd80;
  localparam logic [RowW-1:0]  RowsRst    = 8'd25;
  localparam logic [CodeW-1:0] ReplRst    = 21'd65533;

  // Control and delimiter bytes
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChEsc    = 8'h1b;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuest  = 8'h3f;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5a;
  localparam logic [7:0] ChLbrack = 8'h5b;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoZ    = 8'h7a;

  // UTF-8 lead byte ranges
  localparam logic [7:0] AsciiMax = 8'h7f;
  localparam logic [7:0] LeadMask = 8'hc0;
  localparam logic [7:0] Lead2Max = 8'hdf;
  localparam logic [7:0] Lead3Max = 8'hef;
  localparam logic [7:0] Lead4Max = 8'hf7;

  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_REPL    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_ESC    = 2'd2,
    ACT_REPORT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SEQ_CONT  = 2'd0,
    SEQ_DONE  = 2'd1,
    SEQ_ABORT = 2'd2
  } seq_status_e;

  // All results of one byte: optional scroll, a run of cell writes on one
  // row, optional escape byte, and the closing cursor report
  typedef struct packed {
    logic              scroll;
    logic [CntW-1:0]   wr_cnt;
    logic [ColW-1:0]   wr_col;
    logic [RowW-1:0]   wr_row;
    logic [CodeW-1:0]  wr_code;
    logic              esc;
    logic [7:0]        esc_byte;
    seq_status_e       esc_st;
    logic              esc_priv;
    logic [ColW-1:0]   rep_col;
    logic [RowW-1:0]   rep_row;
    logic              rep_shown;
  } burst_t;

endpackage

>>> sv/terminal_byte_cursor_engine_core.sv
// An accepted byte's results are registered into the burst queue as one burst.
// Each byte yields 1 to TAB_STOP+1 results (up to 3 if TAB_STOP is 1), sent one per
// cycle over the output port while out_ready_i is high. The output port sets the
// rate; a new byte is taken every cycle while the two-entry burst queue has room.
// Reset (async, active low) clears cursor, UTF-8 and escape state and the queue,
// and loads 80 columns, 25 rows and replacement code U+FFFD.
`include "terminal_byte_cursor_engine_core_defines.svh"

module terminal_byte_cursor_engine_core #(
  parameter int unsigned ESC_MAX_LEN = 64,
  parameter int unsigned TAB_STOP    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i,
  // Byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  // Results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [7:0]  column_o,
  output logic [7:0]  row_o,
  output logic [20:0] code_o,
  output logic [1:0]  seq_status_o,
  output logic        private_seq_o,
  output logic        cursor_shown_o,
  output logic        last_o
);

  localparam int unsigned CntW  = tbce_pkg::CntW;
  localparam int unsigned CodeW = tbce_pkg::CodeW;

  // Configuration and cursor state
  logic [7:0]         cols_q, rows_q;
  logic [CodeW-1:0]   repl_q;
  logic [7:0]         col_q, col_d;
  logic [7:0]         row_q, row_d;
  logic               wp_q, wp_d;
  logic               wl_q, wl_d;
  logic [2:0]         utf_have_q, utf_have_d;
  logic [2:0]         utf_need_q, utf_need_d;
  logic [CodeW-1:0]   utf_acc_q, utf_acc_d;
  logic [tbce_pkg::EscCntW-1:0] esc_cnt_q, esc_cnt_d;
  logic               esc_priv_q, esc_priv_d;

  // Burst queue
  tbce_pkg::burst_t   a_q, b_q, burst_new, a_adv;
  logic               a_valid_q, b_valid_q;

  logic [7:0]         ec, er, cfg_ec, cfg_er;
  logic               accept, out_fire, a_last, pop;
  logic [CntW-1:0]    tab_gap [256];

  assign ec     = (cols_q == 8'd0) ? 8'd1 : cols_q;
  assign er     = (rows_q == 8'd0) ? 8'd1 : rows_q;
  assign cfg_ec = (cfg_data_i[7:0] == 8'd0) ? 8'd1 : cfg_data_i[7:0];
  assign cfg_er = (cfg_data_i[7:0] == 8'd0) ? 8'd1 : cfg_data_i[7:0];

  // Distance to the next tab stop for every column
  for (genvar g = 0; g < 256; g++) begin : g_tab
    assign tab_gap[g] = CntW'(TAB_STOP - (g % TAB_STOP));
  end

  // Decode one byte against the current state
  always_comb begin
    logic [7:0]       b;
    logic [8:0]       row9;
    logic [8:0]       tab_end;
    logic [7:0]       pcol;
    logic [8:0]       pcol9;
    logic             pwp;
    logic             pready;
    logic [CodeW-1:0] pcode;
    logic [7:0]       cnt;
    logic             fin;
    tbce_pkg::seq_status_e st;

    b          = byte_in_i;
    col_d      = col_q;
    row_d      = row_q;
    wp_d       = wp_q;
    wl_d       = wl_q;
    utf_have_d = utf_have_q;
    utf_need_d = utf_need_q;
    utf_acc_d  = utf_acc_q;
    esc_cnt_d  = esc_cnt_q;
    esc_priv_d = esc_priv_q;
    burst_new  = '0;
    burst_new.esc_st = tbce_pkg::SEQ_CONT;

    row9    = {1'b0, row_q} + 9'd1;
    tab_end = {1'b0, col_q} + 9'(tab_gap[col_q]);
    pcol    = col_q;
    pcol9   = '0;
    pwp     = wp_q;
    pready  = 1'b1;
    pcode   = {13'd0, b};
    cnt     = {1'b0, esc_cnt_q} + 8'd1;
    fin     = (b inside {[tbce_pkg::ChUpA : tbce_pkg::ChUpZ],
                         [tbce_pkg::ChLoA : tbce_pkg::ChLoZ], tbce_pkg::ChAt});
    st      = tbce_pkg::SEQ_CONT;

    if (b == tbce_pkg::ChCr) begin
      // Return to column zero
      col_d = 8'd0;
      wp_d  = 1'b0;
    end else if (b == tbce_pkg::ChLf) begin
      // Advance a row unless the last printable wrapped
      if (!wl_q) begin
        if (row9 >= {1'b0, er}) begin
          burst_new.scroll = 1'b1;
          row_d = er - 8'd1;
        end else begin
          row_d = row9[7:0];
        end
      end
      wl_d = 1'b0;
    end else if (b == tbce_pkg::ChTab) begin
      // Fill spaces to the next stop, or park at the line end
      if (tab_end <= {1'b0, ec}) begin
        burst_new.wr_cnt  = tab_gap[col_q];
        burst_new.wr_col  = col_q;
        burst_new.wr_row  = row_q;
        burst_new.wr_code = {13'd0, tbce_pkg::ChSpace};
        if (tab_end >= {1'b0, ec}) begin
          col_d = ec;
          wp_d  = 1'b1;
        end else begin
          col_d = tab_end[7:0];
        end
      end else begin
        col_d = ec;
        wp_d  = 1'b1;
      end
    end else if (b == tbce_pkg::ChEsc || esc_cnt_q != '0) begin
      // Collect an escape byte and classify the sequence
      if (cnt == 8'd2 && b != tbce_pkg::ChLbrack) begin
        st = tbce_pkg::SEQ_ABORT;
      end else if (cnt > 8'd2 && fin) begin
        st = tbce_pkg::SEQ_DONE;
        burst_new.esc_priv = esc_priv_q;
      end else if (cnt == 8'd3 && b == tbce_pkg::ChQuest) begin
        esc_priv_d = 1'b1;
      end
      if (st == tbce_pkg::SEQ_CONT && cnt >= 8'(ESC_MAX_LEN)) begin
        st = tbce_pkg::SEQ_ABORT;
      end
      if (st != tbce_pkg::SEQ_CONT) begin
        esc_cnt_d  = '0;
        esc_priv_d = 1'b0;
      end else begin
        esc_cnt_d = cnt[6:0];
      end
      burst_new.esc      = 1'b1;
      burst_new.esc_byte = b;
      burst_new.esc_st   = st;
    end else if (b == tbce_pkg::ChBs) begin
      // Step back one column
      col_d = (col_q > 8'd1) ? col_q - 8'd1 : 8'd0;
      if (col_d < ec) begin
        wp_d = 1'b0;
      end
    end else begin
      // Resolve a pending wrap, scrolling first if needed
      if (col_q < ec) begin
        pwp = 1'b0;
      end
      if (pwp) begin
        pcol = 8'd0;
        wl_d = 1'b1;
        if (row9 >= {1'b0, er}) begin
          burst_new.scroll = 1'b1;
          row_d = er - 8'd1;
        end else begin
          row_d = row9[7:0];
        end
      end else begin
        wl_d = 1'b0;
      end
      if (pcol >= ec) begin
        pcol = ec - 8'd1;
      end

      // UTF-8 decode
      if (b <= tbce_pkg::AsciiMax) begin
        if (utf_need_q != 3'd0) begin
          pcode = repl_q;
        end
        utf_have_d = 3'd0;
        utf_need_d = 3'd0;
        utf_acc_d  = '0;
      end else if ((b & tbce_pkg::LeadMask) == tbce_pkg::LeadMask) begin
        utf_have_d = 3'd0;
        utf_need_d = 3'd0;
        utf_acc_d  = '0;
        if (b <= tbce_pkg::Lead2Max) begin
          utf_need_d = 3'd2;
          utf_acc_d  = {16'd0, b[4:0]};
        end else if (b <= tbce_pkg::Lead3Max) begin
          utf_need_d = 3'd3;
          utf_acc_d  = {17'd0, b[3:0]};
        end else if (b <= tbce_pkg::Lead4Max) begin
          utf_need_d = 3'd4;
          utf_acc_d  = {18'd0, b[2:0]};
        end
        if (utf_need_d != 3'd0) begin
          utf_have_d = 3'd1;
          pready     = 1'b0;
        end else begin
          pcode = repl_q;
        end
      end else begin
        if (utf_need_q == 3'd0) begin
          pcode = repl_q;
        end else begin
          utf_acc_d  = {utf_acc_q[14:0], b[5:0]};
          utf_have_d = utf_have_q + 3'd1;
          if (utf_have_d >= utf_need_q) begin
            pcode      = utf_acc_d;
            utf_have_d = 3'd0;
            utf_need_d = 3'd0;
            utf_acc_d  = '0;
          end else begin
            pready = 1'b0;
          end
        end
      end

      // Write the cell and advance
      col_d = pcol;
      wp_d  = 1'b0;
      if (pready) begin
        burst_new.wr_cnt  = CntW'(1);
        burst_new.wr_col  = pcol;
        burst_new.wr_row  = row_d;
        burst_new.wr_code = pcode;
        pcol9 = {1'b0, pcol} + 9'd1;
        if (pcol9 >= {1'b0, ec}) begin
          col_d = ec;
          wp_d  = 1'b1;
        end else begin
          col_d = pcol9[7:0];
        end
      end
    end

    burst_new.rep_col   = col_d;
    burst_new.rep_row   = row_d;
    burst_new.rep_shown = !wp_d;
  end

  // Handshakes
  assign in_ready_o  = !b_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = a_valid_q;
  assign out_fire    = a_valid_q && out_ready_i;
  assign pop         = out_fire && a_last;

  // Present the head result of the front burst
  always_comb begin
    tbce_pkg::action_e act;
    act            = tbce_pkg::ACT_REPORT;
    column_o       = 8'd0;
    row_o          = 8'd0;
    code_o         = '0;
    seq_status_o   = tbce_pkg::SEQ_CONT;
    private_seq_o  = 1'b0;
    cursor_shown_o = 1'b0;
    a_last         = 1'b0;
    a_adv          = a_q;
    if (a_q.scroll) begin
      act          = tbce_pkg::ACT_SCROLL;
      a_adv.scroll = 1'b0;
    end else if (a_q.wr_cnt != '0) begin
      act          = tbce_pkg::ACT_WRITE;
      column_o     = a_q.wr_col;
      row_o        = a_q.wr_row;
      code_o       = a_q.wr_code;
      a_adv.wr_cnt = a_q.wr_cnt - CntW'(1);
      a_adv.wr_col = a_q.wr_col + 8'd1;
    end else if (a_q.esc) begin
      act           = tbce_pkg::ACT_ESC;
      code_o        = {13'd0, a_q.esc_byte};
      seq_status_o  = a_q.esc_st;
      private_seq_o = a_q.esc_priv;
      a_adv.esc     = 1'b0;
    end else begin
      column_o       = a_q.rep_col;
      row_o          = a_q.rep_row;
      cursor_shown_o = a_q.rep_shown;
      a_last         = 1'b1;
    end
    action_o = act;
    last_o   = a_last;
  end

  // Configuration and cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= tbce_pkg::ColumnsRst;
      rows_q     <= tbce_pkg::RowsRst;
      repl_q     <= tbce_pkg::ReplRst;
      col_q      <= '0;
      row_q      <= '0;
      wp_q       <= 1'b0;
      wl_q       <= 1'b0;
      utf_have_q <= '0;
      utf_need_q <= '0;
      utf_acc_q  <= '0;
      esc_cnt_q  <= '0;
      esc_priv_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tbce_pkg::CFG_COLUMNS: begin
          cols_q <= cfg_data_i[7:0];
          if (col_q >= cfg_ec) begin
            col_q <= cfg_ec;
            wp_q  <= 1'b1;
          end else begin
            wp_q <= 1'b0;
          end
        end
        tbce_pkg::CFG_ROWS: begin
          rows_q <= cfg_data_i[7:0];
          if (row_q >= cfg_er) begin
            row_q <= cfg_er - 8'd1;
          end
        end
        tbce_pkg::CFG_REPL: begin
          repl_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      col_q      <= col_d;
      row_q      <= row_d;
      wp_q       <= wp_d;
      wl_q       <= wl_d;
      utf_have_q <= utf_have_d;
      utf_need_q <= utf_need_d;
      utf_acc_q  <= utf_acc_d;
      esc_cnt_q  <= esc_cnt_d;
      esc_priv_q <= esc_priv_d;
    end
  end

  // Two-entry burst queue: front drains to the output, back holds the next byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (!a_valid_q || pop) begin
      if (b_valid_q) begin
        a_valid_q <= 1'b1;
        b_valid_q <= 1'b0;
      end else begin
        a_valid_q <= accept;
      end
    end else if (accept) begin
      b_valid_q <= 1'b1;
    end
  end

  // Burst payloads
  always_ff @(posedge clk_i) begin
    if (!a_valid_q || pop) begin
      if (b_valid_q) begin
        a_q <= b_q;
      end else if (accept) begin
        a_q <= burst_new;
      end
    end else begin
      if (out_fire) begin
        a_q <= a_adv;
      end
      if (accept) begin
        b_q <= burst_new;
      end
    end
  end

  `TBCE_ASSERT_HOLDS(a_row_on_screen, clk_i, rst_ni, row_q < er, "cursor row off screen")
  `TBCE_ASSERT_HOLDS(a_wrap_at_end, clk_i, rst_ni, wp_q == (col_q == ec), "wrap mark and column disagree")
  `TBCE_ASSERT_HOLDS(a_esc_bound, clk_i, rst_ni, 32'(esc_cnt_q) < ESC_MAX_LEN, "escape count overran")
  `TBCE_ASSERT_HOLDS(a_utf_order, clk_i, rst_ni, (utf_have_q < utf_need_q) || (utf_have_q == 3'd0 && utf_need_q == 3'd0), "utf counts inconsistent")
  `TBCE_ASSERT_IMPLY(a_queue_order, clk_i, rst_ni, b_valid_q, a_valid_q, "back burst without front burst")
  `TBCE_ASSERT_NEXT(a_back_fill, clk_i, rst_ni, accept && a_valid_q && !pop, b_valid_q, "byte lost while front busy")

endmodule

>>> dv/testbench.sv
// Self-checking testbench for terminal_byte_cursor_engine_core.
// Predicts cell writes, scrolls, escape bytes and cursor reports in-line.
// Depends on tbce_pkg and the core RTL only.
module testbench;

  localparam int unsigned TabStop   = 8;
  localparam int unsigned EscMaxLen = 64;

  typedef struct {
    tbce_pkg::action_e     act;
    logic [7:0]            col;
    logic [7:0]            row;
    logic [20:0]           code;
    tbce_pkg::seq_status_e st;
    logic                  priv;
    logic                  shown;
    logic                  last;
  } engine_action_t;

  // Clock, reset and block ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [20:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  action_o;
  logic [7:0]  column_o;
  logic [7:0]  row_o;
  logic [20:0] code_o;
  logic [1:0]  seq_status_o;
  logic        private_seq_o;
  logic        cursor_shown_o;
  logic        last_o;

  // Shadow of the registers and the cursor engine state
  int unsigned cols_reg = tbce_pkg::ColumnsRst;
  int unsigned rows_reg = tbce_pkg::RowsRst;
  logic [20:0] repl_reg = tbce_pkg::ReplRst;
  int unsigned cur_col = 0;
  int unsigned cur_row = 0;
  bit          wrap_armed = 1'b0;
  bit          wrapped_mark = 1'b0;
  int unsigned utf_got = 0;
  int unsigned utf_want = 0;
  logic [20:0] utf_code = '0;
  int unsigned esc_len = 0;
  bit          esc_query = 1'b0;

  // Traffic bookkeeping
  logic [7:0]     shell_bytes [$];
  engine_action_t engine_actions [$];
  int unsigned    bytes_queued = 0;
  int unsigned    bytes_accepted = 0;
  int unsigned    mismatches = 0;
  int unsigned    send_gap = 0;
  int unsigned    send_gap_max = 5;
  int unsigned    recv_stall = 0;
  int unsigned    recv_stall_max = 5;

  // Opening stream on a 10 x 3 screen: wrap, suppressed newline, UTF-8
  // errors, scroll, private and abandoned escapes
  logic [7:0] opening_bytes [0:23] = '{
    8'h61, tbce_pkg::ChTab, tbce_pkg::ChTab, 8'h63, tbce_pkg::ChLf, 8'hc3,
    8'ha9, 8'h80, 8'hff, 8'hc3, 8'h41, 8'he2,
    8'hc3, 8'ha9, tbce_pkg::ChBs, tbce_pkg::ChLf, tbce_pkg::ChLf, tbce_pkg::ChEsc,
    tbce_pkg::ChLbrack, tbce_pkg::ChQuest, 8'h6c, tbce_pkg::ChEsc, 8'h78, 8'h00
  };

  terminal_byte_cursor_engine_core #(
    .ESC_MAX_LEN (EscMaxLen),
    .TAB_STOP    (TabStop)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_in_i      (byte_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .action_o       (action_o),
    .column_o       (column_o),
    .row_o          (row_o),
    .code_o         (code_o),
    .seq_status_o   (seq_status_o),
    .private_seq_o  (private_seq_o),
    .cursor_shown_o (cursor_shown_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_cols();
    return (cols_reg == 0) ? 1 : cols_reg;
  endfunction

  function automatic int unsigned eff_rows();
    return (rows_reg == 0) ? 1 : rows_reg;
  endfunction

  function automatic void push_action(tbce_pkg::action_e act, int unsigned col,
                                      int unsigned row, logic [20:0] code,
                                      tbce_pkg::seq_status_e st, bit priv,
                                      bit shown, bit last);
    engine_action_t a;
    a.act   = act;
    a.col   = 8'(col);
    a.row   = 8'(row);
    a.code  = code;
    a.st    = st;
    a.priv  = priv;
    a.shown = shown;
    a.last  = last;
    engine_actions.push_back(a);
  endfunction

  // Scroll up when the cursor row falls off the bottom
  function automatic void scroll_check();
    if (cur_row >= eff_rows()) begin
      push_action(tbce_pkg::ACT_SCROLL, 0, 0, '0, tbce_pkg::SEQ_CONT, 1'b0, 1'b0, 1'b0);
      cur_row = eff_rows() - 1;
    end
  endfunction

  // Write one cell and advance, arming the wrap at the line end
  function automatic void cell_write(logic [20:0] code);
    push_action(tbce_pkg::ACT_WRITE, cur_col, cur_row, code, tbce_pkg::SEQ_CONT,
                1'b0, 1'b0, 1'b0);
    cur_col++;
    if (cur_col >= eff_cols()) begin
      cur_col    = eff_cols();
      wrap_armed = 1'b1;
    end
  endfunction

  // Update the cursor state for one shell byte and queue its actions
  function automatic void apply_shell_byte(logic [7:0] b);
    logic [20:0] glyph;
    bit          complete;
    bit          final_ch;
    bit          priv;
    int unsigned seq_len;
    int unsigned stop;
    tbce_pkg::seq_status_e st;
    if (b == tbce_pkg::ChCr) begin
      cur_col    = 0;
      wrap_armed = 1'b0;
    end else if (b == tbce_pkg::ChLf) begin
      if (!wrapped_mark) begin
        cur_row++;
        scroll_check();
      end
      wrapped_mark = 1'b0;
    end else if (b == tbce_pkg::ChTab) begin
      stop = TabStop - (cur_col % TabStop);
      if (cur_col + stop <= eff_cols()) begin
        for (int i = 0; i < stop; i++) cell_write(21'(tbce_pkg::ChSpace));
      end else begin
        cur_col    = eff_cols();
        wrap_armed = 1'b1;
      end
    end else if (b == tbce_pkg::ChEsc || esc_len != 0) begin
      // Collect the escape byte and classify it
      seq_len  = esc_len + 1;
      st       = tbce_pkg::SEQ_CONT;
      priv     = 1'b0;
      final_ch = (b >= tbce_pkg::ChUpA && b <= tbce_pkg::ChUpZ) ||
                 (b >= tbce_pkg::ChLoA && b <= tbce_pkg::ChLoZ) || b == tbce_pkg::ChAt;
      if (seq_len == 2 && b != tbce_pkg::ChLbrack) begin
        st = tbce_pkg::SEQ_ABORT;
      end else if (seq_len > 2 && final_ch) begin
        st   = tbce_pkg::SEQ_DONE;
        priv = esc_query;
      end else if (seq_len == 3 && b == tbce_pkg::ChQuest) begin
        esc_query = 1'b1;
      end
      if (st == tbce_pkg::SEQ_CONT && seq_len >= EscMaxLen) st = tbce_pkg::SEQ_ABORT;
      if (st != tbce_pkg::SEQ_CONT) begin
        esc_len   = 0;
        esc_query = 1'b0;
      end else begin
        esc_len = seq_len;
      end
      push_action(tbce_pkg::ACT_ESC, 0, 0, 21'(b), st, priv, 1'b0, 1'b0);
    end else if (b == tbce_pkg::ChBs) begin
      cur_col = (cur_col > 1) ? cur_col - 1 : 0;
      if (cur_col < eff_cols()) wrap_armed = 1'b0;
    end else begin
      // Printable path: resolve a pending wrap first
      glyph    = 21'(b);
      complete = 1'b1;
      if (cur_col < eff_cols()) wrap_armed = 1'b0;
      if (wrap_armed) begin
        cur_col      = 0;
        cur_row++;
        wrapped_mark = 1'b1;
        wrap_armed   = 1'b0;
        scroll_check();
      end else begin
        wrapped_mark = 1'b0;
      end
      if (cur_col >= eff_cols()) cur_col = eff_cols() - 1;
      // UTF-8 decode
      if (b <= tbce_pkg::AsciiMax) begin
        if (utf_want != 0) glyph = repl_reg;
        utf_got  = 0;
        utf_want = 0;
        utf_code = '0;
      end else if ((b & tbce_pkg::LeadMask) == tbce_pkg::LeadMask) begin
        utf_got  = 0;
        utf_want = 0;
        utf_code = '0;
        if (b <= tbce_pkg::Lead2Max) begin
          utf_want = 2;
          utf_code = 21'(b & 8'h1f);
        end else if (b <= tbce_pkg::Lead3Max) begin
          utf_want = 3;
          utf_code = 21'(b & 8'h0f);
        end else if (b <= tbce_pkg::Lead4Max) begin
          utf_want = 4;
          utf_code = 21'(b & 8'h07);
        end
        if (utf_want != 0) begin
          utf_got  = 1;
          complete = 1'b0;
        end else begin
          glyph = repl_reg;
        end
      end else if (utf_want == 0) begin
        glyph = repl_reg;
      end else begin
        utf_code = {utf_code[14:0], b[5:0]};
        utf_got++;
        if (utf_got >= utf_want) begin
          glyph    = utf_code;
          utf_got  = 0;
          utf_want = 0;
          utf_code = '0;
        end else begin
          complete = 1'b0;
        end
      end
      if (complete) cell_write(glyph);
    end
    push_action(tbce_pkg::ACT_REPORT, cur_col, cur_row, '0, tbce_pkg::SEQ_CONT, 1'b0,
                !wrap_armed, 1'b1);
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    shell_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // ESC '[' with optional '?', a parameter body and a final letter or '@'; a long
  // body runs past the length limit and gets abandoned
  function automatic void queue_escape(int unsigned body_len, bit query);
    int unsigned pick;
    queue_byte(tbce_pkg::ChEsc);
    queue_byte(tbce_pkg::ChLbrack);
    if (query) queue_byte(tbce_pkg::ChQuest);
    for (int i = 0; i < body_len; i++) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0: queue_byte(tbce_pkg::ChCr);
        1: queue_byte(tbce_pkg::ChLf);
        2: queue_byte(tbce_pkg::ChTab);
        3: queue_byte(tbce_pkg::ChBs);
        4: queue_byte(tbce_pkg::ChEsc);
        5, 6: queue_byte(8'h3b);
        default: queue_byte(8'h30 + 8'($urandom_range(0, 9)));
      endcase
    end
    pick = $urandom_range(0, 52);
    if (pick < 26) queue_byte(tbce_pkg::ChUpA + 8'(pick));
    else if (pick < 52) queue_byte(tbce_pkg::ChLoA + 8'(pick - 26));
    else queue_byte(tbce_pkg::ChAt);
  endfunction

  // One random fragment of shell output, mostly well formed
  function automatic void queue_random_chunk();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  lead;
    kind = $urandom_range(0, 99);
    if (kind < 22) begin
      n = $urandom_range(1, 12);
      repeat (n) queue_byte(8'($urandom_range(32, 126)));
    end else if (kind < 36) begin
      // Complete UTF-8 character of 2, 3 or 4 bytes
      n = $urandom_range(2, 4);
      case (n)
        2: queue_byte({3'b110, 5'($urandom)});
        3: queue_byte({4'b1110, 4'($urandom)});
        default: queue_byte({5'b11110, 3'($urandom)});
      endcase
      repeat (n - 1) queue_byte({2'b10, 6'($urandom)});
    end else if (kind < 46) begin
      // Broken UTF-8
      case ($urandom_range(0, 3))
        0: queue_byte({2'b10, 6'($urandom)});
        1: queue_byte(8'($urandom_range(248, 255)));
        default: begin
          lead = ($urandom_range(0, 1) == 1) ? {4'b1110, 4'($urandom)}
                                             : {5'b11110, 3'($urandom)};
          queue_byte(lead);
          if ($urandom_range(0, 1) == 1) queue_byte({2'b10, 6'($urandom)});
          if ($urandom_range(0, 1) == 1) queue_byte(8'($urandom_range(32, 126)));
          else queue_byte({3'b110, 5'($urandom)});
        end
      endcase
    end else if (kind < 58) begin
      case ($urandom_range(0, 5))
        0: queue_byte(tbce_pkg::ChCr);
        1: queue_byte(tbce_pkg::ChLf);
        2: begin
          queue_byte(tbce_pkg::ChCr);
          queue_byte(tbce_pkg::ChLf);
        end
        3: queue_byte(tbce_pkg::ChBs);
        default: repeat ($urandom_range(1, 3)) queue_byte(tbce_pkg::ChTab);
      endcase
    end else if (kind < 74) begin
      queue_escape($urandom_range(0, 6), $urandom_range(0, 2) == 0);
    end else if (kind < 78) begin
      queue_byte(tbce_pkg::ChEsc);
      lead = 8'($urandom);
      queue_byte((lead == tbce_pkg::ChLbrack) ? 8'h5d : lead);
    end else if (kind < 80) begin
      queue_escape($urandom_range(62, 70), 1'b0);
    end else begin
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
    end
  endfunction

  // Random bits above the 8-bit geometry value are ignored by the block
  function automatic logic [20:0] geometry_word(int unsigned v);
    return {13'($urandom), 8'(v)};
  endfunction

  // Write a register and apply the same change to the shadow state
  task automatic write_register(tbce_pkg::cfg_idx_e idx, logic [20:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      tbce_pkg::CFG_COLUMNS: begin
        cols_reg = value[7:0];
        if (cur_col >= eff_cols()) begin
          cur_col    = eff_cols();
          wrap_armed = 1'b1;
        end else begin
          wrap_armed = 1'b0;
        end
      end
      tbce_pkg::CFG_ROWS: begin
        rows_reg = value[7:0];
        if (cur_row >= eff_rows()) cur_row = eff_rows() - 1;
      end
      default: repl_reg = value;
    endcase
  endtask

  // Hold until every queued byte is taken and every action has come back
  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || engine_actions.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Present queued bytes with a random gap before each one
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    logic next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      byte_in_i  <= '0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        apply_shell_byte(byte_in_i);
        bytes_accepted++;
        next_valid = 1'b0;
        send_gap   = $urandom_range(0, send_gap_max);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (shell_bytes.size() != 0) begin
          byte_in_i  <= shell_bytes.pop_front();
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Compare each result transaction with the oldest predicted action
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    engine_action_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (engine_actions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: act=%0d col=%0d row=%0d code=%h last=%0d",
                     action_o, column_o, row_o, code_o, last_o);
        end else begin
          want = engine_actions.pop_front();
          if (action_o !== want.act || column_o !== want.col || row_o !== want.row ||
              code_o !== want.code || seq_status_o !== want.st ||
              private_seq_o !== want.priv || cursor_shown_o !== want.shown ||
              last_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display(
                "expected: act=%0d col=%0d row=%0d code=%h st=%0d priv=%0d shown=%0d last=%0d",
                want.act, want.col, want.row, want.code, want.st, want.priv,
                want.shown, want.last);
              $display(
                "actual:   act=%0d col=%0d row=%0d code=%h st=%0d priv=%0d shown=%0d last=%0d",
                action_o, column_o, row_o, code_o, seq_status_o, private_seq_o,
                cursor_shown_o, last_o);
            end
          end
        end
        recv_stall = $urandom_range(0, recv_stall_max);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_ready_i <= (recv_stall == 0);
    end
  end

  initial begin : stimulus
    int unsigned phase_bytes;
    int unsigned cols_val;
    int unsigned rows_val;
    logic [20:0] repl_val;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening on a small screen
    write_register(tbce_pkg::CFG_COLUMNS, geometry_word(10));
    write_register(tbce_pkg::CFG_ROWS, geometry_word(3));
    write_register(tbce_pkg::CFG_REPL, 21'h1fffff);
    foreach (opening_bytes[i]) queue_byte(opening_bytes[i]);
    wait_drained();

    // Random phases over several geometries, extremes included
    for (int phase = 0; phase < 8; phase++) begin
      repl_val = 21'($urandom);
      case (phase)
        0: begin
          cols_val = 0;
          rows_val = 0;
          repl_val = '0;
        end
        1: begin
          cols_val = 255;
          rows_val = 255;
          repl_val = 21'h1fffff;
        end
        2: begin
          cols_val = 1;
          rows_val = 1;
        end
        3: begin
          cols_val = 8;
          rows_val = 4;
        end
        4: begin
          cols_val = 255;
          rows_val = 2;
        end
        5: begin
          cols_val = 13;
          rows_val = 255;
        end
        6: begin
          cols_val = $urandom_range(1, 40);
          rows_val = $urandom_range(1, 6);
        end
        default: begin
          cols_val = tbce_pkg::ColumnsRst;
          rows_val = tbce_pkg::RowsRst;
          repl_val = tbce_pkg::ReplRst;
        end
      endcase
      write_register(tbce_pkg::CFG_COLUMNS, geometry_word(cols_val));
      write_register(tbce_pkg::CFG_ROWS, geometry_word(rows_val));
      write_register(tbce_pkg::CFG_REPL, repl_val);
      send_gap_max   = (phase % 3 == 1) ? 0 : 5;
      recv_stall_max = (phase % 4 == 2) ? 0 : 5;
      phase_bytes    = bytes_queued;
      if (phase == 4) queue_escape(66, 1'b1);
      while (bytes_queued - phase_bytes < 26) begin
        queue_random_chunk();
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    mismatches += engine_actions.size();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/tbce_pkg.sv
sv/terminal_byte_cursor_engine_core.sv
dv/testbench.sv
